// ===== rtl/core/deadline_sorted_timer_queue_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Timer queue assertion macros
// Shared concurrent assertion forms for the timer queue modules.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DSTQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DSTQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dstq_pkg.sv =====
// ---------------------------------------------------------------------------
// Timer queue package
// Sizes, codes and the command/status bundles shared by the queue modules.
// ---------------------------------------------------------------------------
package dstq_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 32;
    localparam int MAX_OUT   = 16;

    localparam int KIND_W = 2;
    localparam int ID_W   = 8;
    localparam int PER_W  = 31;
    localparam int RES_W  = 3;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FCNT_W = $clog2(MAX_OUT + 1);
    localparam int FB_W   = $clog2(MAX_OUT);

    localparam int IN_TDATA_W  = ((ID_W + PER_W + 1 + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - (ID_W + PER_W + 1);
    localparam int OUT_TDATA_W = ((RES_W + ID_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (RES_W + ID_W);

    typedef enum logic [KIND_W-1:0] {
        KIND_SCHED  = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_SHUT   = 2'd3
    } kind_t;

    typedef enum logic [RES_W-1:0] {
        RES_ACCEPTED  = 3'd0,
        RES_REJECTED  = 3'd1,
        RES_CANCELLED = 3'd2,
        RES_FIRED     = 3'd3,
        RES_FLUSHED   = 3'd4,
        RES_NONE      = 3'd5
    } res_t;

    typedef enum logic [1:0] {
        ID_PEND = 2'd0,
        ID_HEAD = 2'd1,
        ID_FBUF = 2'd2,
        ID_ZERO = 2'd3
    } id_sel_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] dl;
        logic [ID_W-1:0]      id;
        logic [PER_W-1:0]     per;
        logic                 rep;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] per;
        logic             rep;
    } fire_t;

    typedef struct packed {
        logic    load_in;
        logic    idx_inc;
        logic    insert;
        logic    remove_idx;
        logic    pop_head;
        logic    fbuf_load;
        logic    time_inc;
        logic    stop_run;
        logic    emit;
        res_t    res;
        id_sel_t id_sel;
        logic    last;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  running;
        logic  full;
        logic  empty;
        logic  stop_ins;
        logic  scan_end;
        logic  hit;
        logic  head_due;
        logic  fcnt_zero;
        logic  fb_rep;
        logic  fb_last;
        logic  fbuf_done;
        logic  flush_last;
        logic  out_free;
    } sts_t;

    // a strictly earlier than b, by wrapping signed difference
    function automatic logic earlier(input logic [TIME_BITS-1:0] a,
                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] diff;
        diff = a - b;
        return diff[TIME_BITS-1];
    endfunction

endpackage

// ===== rtl/core/dstq_datapath.sv =====
// ---------------------------------------------------------------------------
// Timer queue datapath
// Sorted entry registers, time counter, fire buffer and result register.
// ---------------------------------------------------------------------------
module dstq_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dstq_pkg::cmd_t                    cmd,
    output dstq_pkg::sts_t                    sts,
    input  logic [dstq_pkg::KIND_W-1:0]       in_kind,
    input  logic [dstq_pkg::ID_W-1:0]         in_task_id,
    input  logic [dstq_pkg::PER_W-1:0]        in_delay,
    input  logic                              in_periodic,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dstq_pkg::OUT_TDATA_W-1:0]  out_data,
    output logic                              out_last
);

    dstq_pkg::entry_t ent_reg [dstq_pkg::DEPTH];
    dstq_pkg::entry_t up_ent  [dstq_pkg::DEPTH];
    dstq_pkg::entry_t dn_ent  [dstq_pkg::DEPTH];
    dstq_pkg::fire_t  fb_reg  [dstq_pkg::MAX_OUT];

    dstq_pkg::entry_t pend_reg;
    dstq_pkg::kind_t  kind_reg;
    dstq_pkg::entry_t scan_ent;
    dstq_pkg::fire_t  fb_cur;

    logic [dstq_pkg::CNT_W-1:0]     count_reg;
    logic [dstq_pkg::CNT_W-1:0]     idx_reg;
    logic [dstq_pkg::FCNT_W-1:0]    fcnt_reg;
    logic [dstq_pkg::FCNT_W-1:0]    fptr_reg;
    logic [dstq_pkg::TIME_BITS-1:0] time_reg;
    logic                           running_reg;

    logic                           out_valid_reg;
    dstq_pkg::res_t                 out_res_reg;
    logic [dstq_pkg::ID_W-1:0]      out_id_reg;
    logic                           out_last_reg;
    logic [dstq_pkg::ID_W-1:0]      emit_id;

    // Neighbor views for insert (shift up) and removal (shift down)
    for (genvar g = 0; g < dstq_pkg::DEPTH; g++) begin : g_nbr
        if (g == 0) begin : g_first
            assign up_ent[g] = pend_reg;
        end
        else begin : g_rest
            assign up_ent[g] = ent_reg[g-1];
        end
        if (g == dstq_pkg::DEPTH - 1) begin : g_top
            assign dn_ent[g] = ent_reg[g];
        end
        else begin : g_low
            assign dn_ent[g] = ent_reg[g+1];
        end
    end

    assign scan_ent = ent_reg[idx_reg[dstq_pkg::IDX_W-1:0]];
    assign fb_cur   = fb_reg[fptr_reg[dstq_pkg::FB_W-1:0]];

    // Shift entries: insert at scan index, remove at scan index, pop head
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < dstq_pkg::DEPTH; j++)
        begin
            if (cmd.insert)
            begin
                if (dstq_pkg::CNT_W'(j) == idx_reg)
                    ent_reg[j] <= pend_reg;
                else if (dstq_pkg::CNT_W'(j) > idx_reg)
                    ent_reg[j] <= up_ent[j];
            end
            else if (cmd.remove_idx)
            begin
                if (dstq_pkg::CNT_W'(j) >= idx_reg)
                    ent_reg[j] <= dn_ent[j];
            end
            else if (cmd.pop_head)
            begin
                ent_reg[j] <= dn_ent[j];
            end
        end
    end

    // Capture popped head into the fire buffer
    always_ff @(posedge clk)
    begin
        if (cmd.pop_head)
            fb_reg[fcnt_reg[dstq_pkg::FB_W-1:0]] <= '{id:  ent_reg[0].id,
                                                       per: ent_reg[0].per,
                                                       rep: ent_reg[0].rep};
    end

    // Pending entry and latched kind
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg     <= dstq_pkg::kind_t'(in_kind);
            pend_reg.dl  <= time_reg + dstq_pkg::TIME_BITS'(in_delay);
            pend_reg.id  <= in_task_id;
            pend_reg.per <= in_delay;
            pend_reg.rep <= in_periodic;
        end
        else if (cmd.fbuf_load)
        begin
            pend_reg.dl  <= time_reg + dstq_pkg::TIME_BITS'(fb_cur.per);
            pend_reg.id  <= fb_cur.id;
            pend_reg.per <= fb_cur.per;
            pend_reg.rep <= 1'b1;
        end
    end

    // Control counters, time and run flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            fcnt_reg    <= '0;
            fptr_reg    <= '0;
            time_reg    <= '0;
            running_reg <= 1'b1;
        end
        else
        begin
            if (cmd.insert)
                count_reg <= count_reg + 1'b1;
            else if (cmd.remove_idx || cmd.pop_head)
                count_reg <= count_reg - 1'b1;

            if (cmd.load_in || cmd.fbuf_load)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;

            if (cmd.load_in)
                fcnt_reg <= '0;
            else if (cmd.pop_head)
                fcnt_reg <= fcnt_reg + 1'b1;

            if (cmd.load_in)
                fptr_reg <= '0;
            else if (cmd.fbuf_load)
                fptr_reg <= fptr_reg + 1'b1;

            if (cmd.time_inc)
                time_reg <= time_reg + 1'b1;

            if (cmd.stop_run)
                running_reg <= 1'b0;
        end
    end

    // Select the id carried by a result
    always_comb
    begin
        unique case (cmd.id_sel)
            dstq_pkg::ID_PEND: emit_id = pend_reg.id;
            dstq_pkg::ID_HEAD: emit_id = ent_reg[0].id;
            dstq_pkg::ID_FBUF: emit_id = fb_cur.id;
            dstq_pkg::ID_ZERO: emit_id = '0;
            default:           emit_id = '0;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_res_reg  <= cmd.res;
            out_id_reg   <= emit_id;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{dstq_pkg::OUT_PAD_W{1'b0}}, out_id_reg, out_res_reg};
    assign out_last  = out_last_reg;

    // Status toward the controller
    always_comb
    begin
        sts.kind       = kind_reg;
        sts.running    = running_reg;
        sts.full       = (count_reg == dstq_pkg::CNT_W'(dstq_pkg::DEPTH));
        sts.empty      = (count_reg == '0);
        sts.stop_ins   = (idx_reg == count_reg) || dstq_pkg::earlier(pend_reg.dl, scan_ent.dl);
        sts.scan_end   = (idx_reg >= count_reg);
        sts.hit        = (scan_ent.id == pend_reg.id);
        sts.head_due   = (count_reg != '0)
                       && !dstq_pkg::earlier(time_reg, ent_reg[0].dl)
                       && (fcnt_reg != dstq_pkg::FCNT_W'(dstq_pkg::MAX_OUT));
        sts.fcnt_zero  = (fcnt_reg == '0);
        sts.fb_rep     = fb_cur.rep;
        sts.fb_last    = ((fptr_reg + 1'b1) == fcnt_reg);
        sts.fbuf_done  = (fptr_reg == fcnt_reg);
        sts.flush_last = (count_reg == dstq_pkg::CNT_W'(1))
                       || ((fcnt_reg + 1'b1) == dstq_pkg::FCNT_W'(dstq_pkg::MAX_OUT));
        sts.out_free   = !out_valid_reg || out_ready;
    end

`include "deadline_sorted_timer_queue_unit_assert.svh"

    `DSTQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= dstq_pkg::CNT_W'(dstq_pkg::DEPTH), "entry count beyond depth")
    `DSTQ_ASSERT_IMP(a_insert_room, clk, rst_n, cmd.insert, count_reg < dstq_pkg::CNT_W'(dstq_pkg::DEPTH), "insert into a full queue")
    `DSTQ_ASSERT_IMP(a_fptr_bound, clk, rst_n, 1'b1, fptr_reg <= fcnt_reg, "fire buffer read passed write")
    `DSTQ_ASSERT_NXT(a_time_step, clk, rst_n, cmd.time_inc, time_reg == $past(time_reg) + 1'b1, "time did not advance by one")

endmodule

// ===== rtl/core/dstq_ctrl.sv =====
// ---------------------------------------------------------------------------
// Timer queue controller
// Sequences schedule, cancel, tick and shutdown over the datapath.
// ---------------------------------------------------------------------------
module dstq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dstq_pkg::sts_t sts,
    output dstq_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_DECODE     = 9'b000000010,
        S_INS_SCAN   = 9'b000000100,
        S_CAN_SCAN   = 9'b000001000,
        S_TICK_POP   = 9'b000010000,
        S_FIRE_EMIT  = 9'b000100000,
        S_REARM_SCAN = 9'b001000000,
        S_FLUSH      = 9'b010000000,
        S_EMIT       = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    dstq_pkg::res_t    res_reg, res_next;
    dstq_pkg::id_sel_t sel_reg, sel_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        sel_next   = sel_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.kind)
                    dstq_pkg::KIND_SCHED:
                    begin
                        if (!sts.running || sts.full)
                        begin
                            res_next   = dstq_pkg::RES_REJECTED;
                            sel_next   = dstq_pkg::ID_PEND;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_INS_SCAN;
                        end
                    end
                    dstq_pkg::KIND_CANCEL:
                    begin
                        state_next = S_CAN_SCAN;
                    end
                    dstq_pkg::KIND_TICK:
                    begin
                        cmd.time_inc = 1'b1;
                        if (!sts.running)
                        begin
                            res_next   = dstq_pkg::RES_NONE;
                            sel_next   = dstq_pkg::ID_ZERO;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_TICK_POP;
                        end
                    end
                    dstq_pkg::KIND_SHUT:
                    begin
                        cmd.stop_run = 1'b1;
                        if (sts.empty)
                        begin
                            res_next   = dstq_pkg::RES_NONE;
                            sel_next   = dstq_pkg::ID_ZERO;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_SCAN:
            begin
                priority if (sts.stop_ins)
                begin
                    cmd.insert = 1'b1;
                    res_next   = dstq_pkg::RES_ACCEPTED;
                    sel_next   = dstq_pkg::ID_PEND;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CAN_SCAN:
            begin
                priority if (sts.scan_end)
                begin
                    res_next   = dstq_pkg::RES_CANCELLED;
                    sel_next   = dstq_pkg::ID_PEND;
                    state_next = S_EMIT;
                end
                else if (sts.hit)
                begin
                    cmd.remove_idx = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_TICK_POP:
            begin
                priority if (sts.head_due)
                begin
                    cmd.pop_head = 1'b1;
                end
                else if (sts.fcnt_zero)
                begin
                    res_next   = dstq_pkg::RES_NONE;
                    sel_next   = dstq_pkg::ID_ZERO;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_FIRE_EMIT;
                end
            end
            S_FIRE_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.res       = dstq_pkg::RES_FIRED;
                    cmd.id_sel    = dstq_pkg::ID_FBUF;
                    cmd.last      = sts.fb_last;
                    cmd.fbuf_load = 1'b1;
                    if (sts.fb_rep)
                        state_next = S_REARM_SCAN;
                    else if (sts.fb_last)
                        state_next = S_IDLE;
                end
            end
            S_REARM_SCAN:
            begin
                priority if (sts.stop_ins)
                begin
                    cmd.insert = 1'b1;
                    state_next = sts.fbuf_done ? S_IDLE : S_FIRE_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.res      = dstq_pkg::RES_FLUSHED;
                    cmd.id_sel   = dstq_pkg::ID_HEAD;
                    cmd.last     = sts.flush_last;
                    cmd.pop_head = 1'b1;
                    if (sts.flush_last)
                        state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.res    = res_reg;
                    cmd.id_sel = sel_reg;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, held result code and held id select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= dstq_pkg::RES_NONE;
            sel_reg   <= dstq_pkg::ID_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            sel_reg   <= sel_next;
        end
    end

`include "deadline_sorted_timer_queue_unit_assert.svh"

    `DSTQ_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free, "result written over a waiting word")
    `DSTQ_ASSERT_NXT(a_idle_hold, clk, rst_n, (state_reg == S_IDLE) && !in_valid, state_reg == S_IDLE, "left idle without a word")
    `DSTQ_ASSERT_IMP(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")

endmodule

// ===== rtl/core/deadline_sorted_timer_queue_unit.sv =====
// Sequence: a rejected schedule goes from decode straight to its result; schedule and cancel
// scan the entries first (one entry scanned per cycle). Tick: decode, pop each due entry into
// the fire buffer, then one fired result per entry, with an insert scan for each that re-arms.
// Shutdown: one flushed result per entry, or a single none result when empty; output stalls hold results.
// Input: one word in flight; the next is taken only after the last result of the previous one.
// Reset: empty queue, time zero, queue running; entry storage is not cleared.
// ---------------------------------------------------------------------------
// Deadline-sorted timer queue
// Timer list sorted by wrapping deadline with schedule, cancel, tick, flush.
// ---------------------------------------------------------------------------
module deadline_sorted_timer_queue_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // task_id [7:0], delay [38:8], periodic [39]
    input  logic [dstq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind [1:0]
    input  logic [dstq_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // event_res [2:0], fired_id [10:3], zero pad above
    output logic [dstq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    dstq_pkg::cmd_t cmd;
    dstq_pkg::sts_t sts;

    logic [dstq_pkg::ID_W-1:0]  in_task_id;
    logic [dstq_pkg::PER_W-1:0] in_delay;
    logic                       in_periodic;

    // Unpack the input word
    assign in_task_id  = s_axis_tdata[dstq_pkg::ID_W-1:0];
    assign in_delay    = s_axis_tdata[dstq_pkg::ID_W +: dstq_pkg::PER_W];
    assign in_periodic = s_axis_tdata[dstq_pkg::ID_W + dstq_pkg::PER_W];

    dstq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dstq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (s_axis_tuser),
        .in_task_id  (in_task_id),
        .in_delay    (in_delay),
        .in_periodic (in_periodic),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule
